// ===== design/double_ended_queue_macros.svh =====
// Assertion shorthands used by the checker file.
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// Same-cycle implication, muted while reset is held.
`define DQ_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("dq assertion failed");

// Next-cycle implication, muted while reset is held.
`define DQ_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("dq assertion failed");

`endif

// ===== design/dq_pkg.sv =====
package dq_pkg;

  localparam int FUNC_W      = 2;
  localparam int DATA_W      = 32;
  localparam int STATUS_W    = 2;
  localparam int FILL_W      = 8;
  localparam int OUT_TDATA_W = DATA_W + FILL_W;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH_BACK  = 2'd0,
    FUNC_PUSH_FRONT = 2'd1,
    FUNC_POP_FRONT  = 2'd2,
    FUNC_POP_BACK   = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_OVERFLOW  = 2'd1,
    STATUS_UNDERFLOW = 2'd2
  } status_t;

  // Store strobes from the pointer logic.
  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

  // Per-request result, minus the popped word which comes from the store.
  typedef struct packed {
    logic                 pop_ok;
    status_t              status;
    logic [FILL_W-1:0]    fill_count;
  } res_t;

endpackage

// ===== design/double_ended_queue.sv =====
// Double-ended queue of 32-bit words in a circular store of DEPTH entries.
// Each input beat is one request (push back, push front, pop front, pop
// back) and yields exactly one output beat with the popped word, a status
// and the new fill count. One request is taken per clock while in_tready is high; its
// result is held in the read stage, beside the single-port store whose read data is
// registered, and then in the output register before it shows on the output. A
// push into a full queue or a pop from an empty one leaves everything as
// is and reports overflow or underflow. The store needs no clearing after
// reset: only pushed words are ever popped.
module double_ended_queue #(
  parameter int DEPTH = 128
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [dq_pkg::DATA_W-1:0]         in_tdata,  // [31:0] push_value
  input  logic [dq_pkg::FUNC_W-1:0]         in_tuser,  // [1:0] func
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [dq_pkg::OUT_TDATA_W-1:0]    out_tdata, // [31:0] pop_value, [39:32] fill_count
  output logic [dq_pkg::STATUS_W-1:0]       out_tuser  // [1:0] status
);

  logic                      accept;
  dq_pkg::mem_ctl_t          mem_ctl;
  logic [$clog2(DEPTH)-1:0]  mem_addr;
  logic [dq_pkg::DATA_W-1:0] mem_wdata;
  logic [dq_pkg::DATA_W-1:0] mem_rdata;
  dq_pkg::res_t              res;

  assign accept = in_tvalid && in_tready;

  dq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .func       (in_tuser),
    .push_value (in_tdata),
    .mem_ctl    (mem_ctl),
    .mem_addr   (mem_addr),
    .mem_wdata  (mem_wdata),
    .res        (res)
  );

  dq_store #(.DEPTH(DEPTH)) u_store (
    .clk       (clk),
    .mem_ctl   (mem_ctl),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata)
  );

  dq_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .res        (res),
    .mem_rdata  (mem_rdata),
    .in_ready   (in_tready),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_data   (out_tdata),
    .out_status (out_tuser)
  );

endmodule

// ===== design/dq_store.sv =====
module dq_store #(
  parameter int DEPTH = 128
) (
  input  logic                           clk,
  input  dq_pkg::mem_ctl_t               mem_ctl,
  input  logic [$clog2(DEPTH)-1:0]       mem_addr,
  input  logic [dq_pkg::DATA_W-1:0]      mem_wdata,
  output logic [dq_pkg::DATA_W-1:0]      mem_rdata
);

  logic [dq_pkg::DATA_W-1:0] mem [DEPTH];
  logic [dq_pkg::DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (mem_ctl.we) begin
      mem[mem_addr] <= mem_wdata;
    end
  end

  // Hold the read word until the next pop.
  always_ff @(posedge clk) begin
    if (mem_ctl.re) begin
      rdata_r <= mem[mem_addr];
    end
  end

  assign mem_rdata = rdata_r;

endmodule

// ===== design/dq_ctrl.sv =====
module dq_ctrl #(
  parameter int DEPTH = 128
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           accept,
  input  logic [dq_pkg::FUNC_W-1:0]      func,
  input  logic [dq_pkg::DATA_W-1:0]      push_value,
  output dq_pkg::mem_ctl_t               mem_ctl,
  output logic [$clog2(DEPTH)-1:0]       mem_addr,
  output logic [dq_pkg::DATA_W-1:0]      mem_wdata,
  output dq_pkg::res_t                   res
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          full, empty;
  logic [SW-1:0] sum_back, sum_last;
  logic [AW-1:0] slot_back, slot_last, head_dec, head_inc;

  always_comb begin
    full  = (count_r == CW'(DEPTH));
    empty = (count_r == '0);

    // head + count stays below twice the depth: one compare and subtract wraps it
    sum_back  = SW'(head_r) + SW'(count_r);
    sum_last  = sum_back - SW'(1);
    slot_back = (sum_back >= SW'(DEPTH)) ? AW'(sum_back - SW'(DEPTH)) : AW'(sum_back);
    slot_last = (sum_last >= SW'(DEPTH)) ? AW'(sum_last - SW'(DEPTH)) : AW'(sum_last);
    head_dec  = (head_r == '0) ? AW'(DEPTH - 1) : head_r - AW'(1);
    head_inc  = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);

    head_nxt   = head_r;
    count_nxt  = count_r;
    mem_ctl    = '0;
    mem_addr   = slot_back;
    mem_wdata  = push_value;
    res.pop_ok = 1'b0;
    res.status = dq_pkg::STATUS_OK;

    case (dq_pkg::func_t'(func))
      dq_pkg::FUNC_PUSH_BACK: begin
        if (full) begin
          res.status = dq_pkg::STATUS_OVERFLOW;
        end else begin
          mem_ctl.we = 1'b1;
          count_nxt  = count_r + CW'(1);
        end
      end
      dq_pkg::FUNC_PUSH_FRONT: begin
        if (full) begin
          res.status = dq_pkg::STATUS_OVERFLOW;
        end else begin
          mem_ctl.we = 1'b1;
          mem_addr   = head_dec;
          head_nxt   = head_dec;
          count_nxt  = count_r + CW'(1);
        end
      end
      dq_pkg::FUNC_POP_FRONT: begin
        if (empty) begin
          res.status = dq_pkg::STATUS_UNDERFLOW;
        end else begin
          mem_ctl.re = 1'b1;
          mem_addr   = head_r;
          head_nxt   = head_inc;
          count_nxt  = count_r - CW'(1);
          res.pop_ok = 1'b1;
        end
      end
      dq_pkg::FUNC_POP_BACK: begin
        if (empty) begin
          res.status = dq_pkg::STATUS_UNDERFLOW;
        end else begin
          mem_ctl.re = 1'b1;
          mem_addr   = slot_last;
          count_nxt  = count_r - CW'(1);
          res.pop_ok = 1'b1;
        end
      end
      default: begin
      end
    endcase

    res.fill_count = dq_pkg::FILL_W'(count_nxt);

    if (!accept) begin
      mem_ctl = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else if (accept) begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

// ===== design/dq_out.sv =====
module dq_out (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              accept,
  input  dq_pkg::res_t                      res,
  input  logic [dq_pkg::DATA_W-1:0]         mem_rdata,
  output logic                              in_ready,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [dq_pkg::OUT_TDATA_W-1:0]    out_data,
  output logic [dq_pkg::STATUS_W-1:0]       out_status
);

  logic                      a_valid_r;
  dq_pkg::res_t              a_res_r;
  logic                      b_valid_r;
  logic [dq_pkg::DATA_W-1:0] b_pop_r;
  dq_pkg::status_t           b_status_r;
  logic [dq_pkg::FILL_W-1:0] b_fill_r;
  logic                      a_adv;

  // Advance the read stage when the output register is free or draining.
  assign a_adv    = a_valid_r && (!b_valid_r || out_ready);
  assign in_ready = !a_valid_r || a_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        a_valid_r <= 1'b1;
      end else if (a_adv) begin
        a_valid_r <= 1'b0;
      end
      if (a_adv) begin
        b_valid_r <= 1'b1;
      end else if (out_ready) begin
        b_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_res_r <= res;
    end
    if (a_adv) begin
      b_pop_r    <= a_res_r.pop_ok ? mem_rdata : '0;
      b_status_r <= a_res_r.status;
      b_fill_r   <= a_res_r.fill_count;
    end
  end

  assign out_valid  = b_valid_r;
  assign out_data   = {b_fill_r, b_pop_r};
  assign out_status = b_status_r;

endmodule

// ===== design/dq_checker.sv =====
`include "double_ended_queue_macros.svh"

module dq_checker #(
  parameter int DEPTH = 128
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [dq_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input logic [dq_pkg::STATUS_W-1:0]       out_tuser
);

  // A stalled output beat holds.
  `DQ_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // Overflow only on a full queue, and nothing is popped.
  `DQ_ASSERT_IMP(a_ovf_full, clk, rst_n, out_tvalid && out_tuser == dq_pkg::STATUS_OVERFLOW, out_tdata[31:0] == 32'd0 && out_tdata[39:32] == 8'(DEPTH))

  // Underflow only on an empty queue, and the word is zero.
  `DQ_ASSERT_IMP(a_udf_empty, clk, rst_n, out_tvalid && out_tuser == dq_pkg::STATUS_UNDERFLOW, out_tdata[31:0] == 32'd0 && out_tdata[39:32] == 8'd0)

  // Status never takes the unused code.
  `DQ_ASSERT_IMP(a_status_code, clk, rst_n, out_tvalid, out_tuser == dq_pkg::STATUS_OK || out_tuser == dq_pkg::STATUS_OVERFLOW || out_tuser == dq_pkg::STATUS_UNDERFLOW)

endmodule

bind double_ended_queue dq_checker #(.DEPTH(DEPTH)) u_dq_checker (.*);
